// ----- rtl/core/tfn_pkg.sv -----
// Shared types and constants of the triangle face normal block.
package tfn_pkg;

    localparam int COORD_W  = 12;
    localparam int INDEX_W  = 10;
    localparam int NORMAL_W = 16;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vert_t;

    localparam coord_t BOX_MIN_RESET = 12'sh7FF;
    localparam coord_t BOX_MAX_RESET = 12'sh800;

    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_C
    } corner_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_CAP_C,
        ST_EDGE,
        ST_PROD,
        ST_CROSS,
        ST_SQUARE,
        ST_SUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_SQRT,
        ST_STORE,
        ST_FINISH
    } state_t;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic        start;
        logic        load_vertex;
        corner_sel_t rd_sel;
        logic        cap_en;
        corner_sel_t cap_sel;
        logic        edge_en;
        logic        prod_en;
        logic        cross_en;
        logic        square_en;
        logic        sum_en;
        logic        mark_degen;
        logic        div_init;
        logic        div_step;
        logic        div_first;
        logic        sqrt_init;
        logic        sqrt_step;
        logic        comp_store;
        logic [1:0]  comp;
        logic        out_load;
    } cmd_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic sum_zero;
    } sts_t;

endpackage

// ----- rtl/core/tfn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tfn_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/tfn_datapath.sv -----
// Datapath: vertex store, bounding box, cross product and shared divide/root unit.
module tfn_datapath #(
    parameter int MAX_VERTICES     = 1024,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  tfn_pkg::cmd_t                         cmd,
    output tfn_pkg::sts_t                         sts,
    input  logic [tfn_pkg::INDEX_W-1:0]           s_vertex_slot,
    input  tfn_pkg::coord_t                       s_coord_x,
    input  tfn_pkg::coord_t                       s_coord_y,
    input  tfn_pkg::coord_t                       s_coord_z,
    input  logic [tfn_pkg::INDEX_W-1:0]           s_corner_a,
    input  logic [tfn_pkg::INDEX_W-1:0]           s_corner_b,
    input  logic [tfn_pkg::INDEX_W-1:0]           s_corner_c,
    output logic signed [tfn_pkg::NORMAL_W-1:0]   m_normal_x,
    output logic signed [tfn_pkg::NORMAL_W-1:0]   m_normal_y,
    output logic signed [tfn_pkg::NORMAL_W-1:0]   m_normal_z,
    output logic                                  m_degenerate,
    output tfn_pkg::coord_t                       m_box_min_x,
    output tfn_pkg::coord_t                       m_box_min_y,
    output tfn_pkg::coord_t                       m_box_min_z,
    output tfn_pkg::coord_t                       m_box_max_x,
    output tfn_pkg::coord_t                       m_box_max_y,
    output tfn_pkg::coord_t                       m_box_max_z
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int F  = NORMAL_FRAC_BITS;
    localparam int QW = 2 * F + 2;   // quotient bits, padded to even
    localparam int RW = F + 2;       // root remainder
    localparam int TW = F + 1;       // root
    localparam int NW = tfn_pkg::NORMAL_W;
    localparam int SW = 52;          // squares and their sum
    localparam int MW = 26;          // magnitude of a cross component

    // ---------------- vertex store ----------------
    logic [31:0]      slot_ext;
    logic             slot_ok;
    logic [AW-1:0]    raddr;
    logic [35:0]      rdata;
    tfn_pkg::vert_t   wvert;

    logic [tfn_pkg::INDEX_W-1:0] ca_reg, cb_reg, cc_reg;
    logic [31:0]      rd_ext;

    assign slot_ext = 32'(s_vertex_slot);
    assign slot_ok  = slot_ext < 32'(MAX_VERTICES);
    assign wvert    = '{x: s_coord_x, y: s_coord_y, z: s_coord_z};

    // pick the corner to read
    always_comb begin
        case (cmd.rd_sel)
            tfn_pkg::SEL_A: rd_ext = 32'(ca_reg);
            tfn_pkg::SEL_B: rd_ext = 32'(cb_reg);
            tfn_pkg::SEL_C: rd_ext = 32'(cc_reg);
            default:        rd_ext = 32'(ca_reg);
        endcase
    end
    assign raddr = rd_ext[AW-1:0];

    tfn_ram #(
        .WIDTH (36),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.load_vertex && slot_ok),
        .waddr (slot_ext[AW-1:0]),
        .wdata (wvert),
        .raddr (raddr),
        .rdata (rdata)
    );

    // ---------------- bounding box ----------------
    tfn_pkg::coord_t lo_x_reg, lo_y_reg, lo_z_reg, hi_x_reg, hi_y_reg, hi_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_x_reg <= tfn_pkg::BOX_MIN_RESET;
            lo_y_reg <= tfn_pkg::BOX_MIN_RESET;
            lo_z_reg <= tfn_pkg::BOX_MIN_RESET;
            hi_x_reg <= tfn_pkg::BOX_MAX_RESET;
            hi_y_reg <= tfn_pkg::BOX_MAX_RESET;
            hi_z_reg <= tfn_pkg::BOX_MAX_RESET;
        end else if (cmd.load_vertex) begin
            if (s_coord_x < lo_x_reg) lo_x_reg <= s_coord_x;
            if (s_coord_y < lo_y_reg) lo_y_reg <= s_coord_y;
            if (s_coord_z < lo_z_reg) lo_z_reg <= s_coord_z;
            if (s_coord_x > hi_x_reg) hi_x_reg <= s_coord_x;
            if (s_coord_y > hi_y_reg) hi_y_reg <= s_coord_y;
            if (s_coord_z > hi_z_reg) hi_z_reg <= s_coord_z;
        end
    end

    // ---------------- corners and cross product ----------------
    tfn_pkg::vert_t va_reg, vb_reg, vc_reg, cap_next;
    logic           cap_ok;
    logic signed [12:0] e0x_reg, e0y_reg, e0z_reg, e1x_reg, e1y_reg, e1z_reg;
    logic signed [25:0] p_reg [6];
    logic signed [26:0] cx_reg, cy_reg, cz_reg;
    logic [MW-1:0]      mx_next, my_next, mz_next;
    logic [2:0]         sign_reg;
    logic [SW-1:0]      sqx_reg, sqy_reg, sqz_reg, sum_reg;

    // out-of-range corners read as the origin
    always_comb begin
        case (cmd.cap_sel)
            tfn_pkg::SEL_A: cap_ok = 32'(ca_reg) < 32'(MAX_VERTICES);
            tfn_pkg::SEL_B: cap_ok = 32'(cb_reg) < 32'(MAX_VERTICES);
            tfn_pkg::SEL_C: cap_ok = 32'(cc_reg) < 32'(MAX_VERTICES);
            default:        cap_ok = 1'b0;
        endcase
        cap_next = cap_ok ? tfn_pkg::vert_t'(rdata) : '0;
    end

    assign mx_next = MW'(cx_reg < 0 ? -cx_reg : cx_reg);
    assign my_next = MW'(cy_reg < 0 ? -cy_reg : cy_reg);
    assign mz_next = MW'(cz_reg < 0 ? -cz_reg : cz_reg);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            ca_reg <= s_corner_a;
            cb_reg <= s_corner_b;
            cc_reg <= s_corner_c;
        end
        if (cmd.cap_en) begin
            case (cmd.cap_sel)
                tfn_pkg::SEL_A: va_reg <= cap_next;
                tfn_pkg::SEL_B: vb_reg <= cap_next;
                tfn_pkg::SEL_C: vc_reg <= cap_next;
                default:        va_reg <= cap_next;
            endcase
        end
        if (cmd.edge_en) begin
            e0x_reg <= 13'(vb_reg.x) - 13'(va_reg.x);
            e0y_reg <= 13'(vb_reg.y) - 13'(va_reg.y);
            e0z_reg <= 13'(vb_reg.z) - 13'(va_reg.z);
            e1x_reg <= 13'(vc_reg.x) - 13'(va_reg.x);
            e1y_reg <= 13'(vc_reg.y) - 13'(va_reg.y);
            e1z_reg <= 13'(vc_reg.z) - 13'(va_reg.z);
        end
        if (cmd.prod_en) begin
            p_reg[0] <= e0y_reg * e1z_reg;
            p_reg[1] <= e0z_reg * e1y_reg;
            p_reg[2] <= e0z_reg * e1x_reg;
            p_reg[3] <= e0x_reg * e1z_reg;
            p_reg[4] <= e0x_reg * e1y_reg;
            p_reg[5] <= e0y_reg * e1x_reg;
        end
        if (cmd.cross_en) begin
            cx_reg <= 27'(p_reg[0]) - 27'(p_reg[1]);
            cy_reg <= 27'(p_reg[2]) - 27'(p_reg[3]);
            cz_reg <= 27'(p_reg[4]) - 27'(p_reg[5]);
        end
        if (cmd.square_en) begin
            sqx_reg  <= SW'(mx_next) * SW'(mx_next);
            sqy_reg  <= SW'(my_next) * SW'(my_next);
            sqz_reg  <= SW'(mz_next) * SW'(mz_next);
            sign_reg <= {cz_reg < 0, cy_reg < 0, cx_reg < 0};
        end
        if (cmd.sum_en) begin
            sum_reg <= sqx_reg + sqy_reg + sqz_reg;
        end
    end

    assign sts.sum_zero = (sum_reg == '0);

    // ---------------- shared divide and root unit ----------------
    // quotient = floor(c^2 * 2^(2F) / S), then normal = isqrt(quotient)
    logic [SW-1:0] rem_reg, rem_next;
    logic [QW-1:0] xq_reg, xq_next;
    logic [RW-1:0] srem_reg, srem_next;
    logic [TW-1:0] root_reg, root_next;
    logic [SW-1:0] sel_sq;
    logic          sel_sign;
    logic [SW:0]   dtrial;
    logic          dge;
    logic [RW+1:0] sval, strial;
    logic          sge;

    always_comb begin
        case (cmd.comp)
            2'd0:    begin sel_sq = sqx_reg; sel_sign = sign_reg[0]; end
            2'd1:    begin sel_sq = sqy_reg; sel_sign = sign_reg[1]; end
            2'd2:    begin sel_sq = sqz_reg; sel_sign = sign_reg[2]; end
            default: begin sel_sq = sqx_reg; sel_sign = sign_reg[0]; end
        endcase
    end

    always_comb begin
        rem_next  = rem_reg;
        xq_next   = xq_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        dtrial    = cmd.div_first ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        dge       = dtrial >= {1'b0, sum_reg};
        sval      = {srem_reg, xq_reg[QW-1:QW-2]};
        strial    = (RW+2)'({root_reg, 2'b01});
        sge       = sval >= strial;
        if (cmd.div_init) begin
            rem_next = sel_sq;
            xq_next  = '0;
        end
        // restoring divide, one quotient bit per step
        if (cmd.div_step) begin
            rem_next = SW'(dge ? dtrial - {1'b0, sum_reg} : dtrial);
            xq_next  = {xq_reg[QW-2:0], dge};
        end
        if (cmd.sqrt_init) begin
            srem_next = '0;
            root_next = '0;
        end
        // integer root, two radicand bits per step
        if (cmd.sqrt_step) begin
            srem_next = RW'(sge ? sval - strial : sval);
            root_next = {root_reg[TW-2:0], sge};
            xq_next   = {xq_reg[QW-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        xq_reg   <= xq_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    // ---------------- normals and result register ----------------
    logic signed [NW-1:0] nx_reg, ny_reg, nz_reg, nval;
    logic                 degen_reg;

    assign nval = sel_sign ? -NW'(root_reg) : NW'(root_reg);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            nx_reg    <= '0;
            ny_reg    <= '0;
            nz_reg    <= '0;
            degen_reg <= 1'b0;
        end
        if (cmd.mark_degen) begin
            degen_reg <= 1'b1;
        end
        if (cmd.comp_store) begin
            case (cmd.comp)
                2'd0:    nx_reg <= nval;
                2'd1:    ny_reg <= nval;
                2'd2:    nz_reg <= nval;
                default: nx_reg <= nval;
            endcase
        end
        if (cmd.out_load) begin
            m_normal_x   <= nx_reg;
            m_normal_y   <= ny_reg;
            m_normal_z   <= nz_reg;
            m_degenerate <= degen_reg;
            m_box_min_x  <= lo_x_reg;
            m_box_min_y  <= lo_y_reg;
            m_box_min_z  <= lo_z_reg;
            m_box_max_x  <= hi_x_reg;
            m_box_max_y  <= hi_y_reg;
            m_box_max_z  <= hi_z_reg;
        end
    end

endmodule

// ----- rtl/core/tfn_ctrl.sv -----
// Sequencer: steps the datapath through a vertex load or a face normal.
module tfn_ctrl #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_action,
    output logic          m_valid,
    input  logic          m_ready,
    output tfn_pkg::cmd_t cmd,
    input  tfn_pkg::sts_t sts
);

    localparam int F  = NORMAL_FRAC_BITS;
    localparam int CW = $clog2(2 * F + 1);

    tfn_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [1:0]      comp_reg, comp_next;
    logic            m_valid_reg, m_valid_next;

    // hold state, counters and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tfn_pkg::ST_IDLE;
            cnt_reg     <= '0;
            comp_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            comp_reg    <= comp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        s_ready    = 1'b0;
        case (state_reg)
            tfn_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start = 1'b1;
                    if (s_action) begin
                        state_next = tfn_pkg::ST_RD_A;
                    end else begin
                        cmd.load_vertex = 1'b1;
                        state_next      = tfn_pkg::ST_FINISH;
                    end
                end
            end
            tfn_pkg::ST_RD_A: begin
                cmd.rd_sel = tfn_pkg::SEL_A;
                state_next = tfn_pkg::ST_RD_B;
            end
            tfn_pkg::ST_RD_B: begin
                cmd.rd_sel  = tfn_pkg::SEL_B;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = tfn_pkg::SEL_A;
                state_next  = tfn_pkg::ST_RD_C;
            end
            tfn_pkg::ST_RD_C: begin
                cmd.rd_sel  = tfn_pkg::SEL_C;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = tfn_pkg::SEL_B;
                state_next  = tfn_pkg::ST_CAP_C;
            end
            tfn_pkg::ST_CAP_C: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = tfn_pkg::SEL_C;
                state_next  = tfn_pkg::ST_EDGE;
            end
            tfn_pkg::ST_EDGE: begin
                cmd.edge_en = 1'b1;
                state_next  = tfn_pkg::ST_PROD;
            end
            tfn_pkg::ST_PROD: begin
                cmd.prod_en = 1'b1;
                state_next  = tfn_pkg::ST_CROSS;
            end
            tfn_pkg::ST_CROSS: begin
                cmd.cross_en = 1'b1;
                state_next   = tfn_pkg::ST_SQUARE;
            end
            tfn_pkg::ST_SQUARE: begin
                cmd.square_en = 1'b1;
                state_next    = tfn_pkg::ST_SUM;
            end
            tfn_pkg::ST_SUM: begin
                cmd.sum_en = 1'b1;
                comp_next  = '0;
                state_next = tfn_pkg::ST_DIV_INIT;
            end
            tfn_pkg::ST_DIV_INIT: begin
                if (sts.sum_zero) begin
                    cmd.mark_degen = 1'b1;
                    state_next     = tfn_pkg::ST_FINISH;
                end else begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = tfn_pkg::ST_DIV;
                end
            end
            tfn_pkg::ST_DIV: begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CW'(2 * F)) begin
                    cmd.sqrt_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = tfn_pkg::ST_SQRT;
                end
            end
            tfn_pkg::ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CW'(F)) begin
                    state_next = tfn_pkg::ST_STORE;
                end
            end
            tfn_pkg::ST_STORE: begin
                cmd.comp_store = 1'b1;
                if (comp_reg == 2'd2) begin
                    state_next = tfn_pkg::ST_FINISH;
                end else begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = tfn_pkg::ST_DIV_INIT;
                end
            end
            tfn_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = tfn_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tfn_pkg::ST_IDLE;
            end
        endcase
    end

    // advance result valid
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/core/triangle_face_normal_top.sv -----
// Top level of the triangle face normal block.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | action, slot, coords, corners
//  m_      | out       | m_valid / m_ready  | normals, degenerate, bounding box
//
// A vertex load goes from IDLE straight to FINISH. A face steps through the
// corner reads, cross product, squares and sum, then through the shared
// divide and root unit once per component (one setup step, 2F+1 divide
// steps, F+1 root steps, one store step), then loads the result in FINISH;
// a zero-length face skips that unit.
// Reset is synchronous on aresetn and clears the sequencer and the box.
// A waiting result does not block the next transaction; a second result
// waits in FINISH until the output register is free.
module triangle_face_normal_top #(
    parameter int MAX_VERTICES     = 1024,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [tfn_pkg::INDEX_W-1:0]         s_vertex_slot,
    input  tfn_pkg::coord_t                     s_coord_x,
    input  tfn_pkg::coord_t                     s_coord_y,
    input  tfn_pkg::coord_t                     s_coord_z,
    input  logic [tfn_pkg::INDEX_W-1:0]         s_corner_a,
    input  logic [tfn_pkg::INDEX_W-1:0]         s_corner_b,
    input  logic [tfn_pkg::INDEX_W-1:0]         s_corner_c,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tfn_pkg::NORMAL_W-1:0] m_normal_x,
    output logic signed [tfn_pkg::NORMAL_W-1:0] m_normal_y,
    output logic signed [tfn_pkg::NORMAL_W-1:0] m_normal_z,
    output logic                                m_degenerate,
    output tfn_pkg::coord_t                     m_box_min_x,
    output tfn_pkg::coord_t                     m_box_min_y,
    output tfn_pkg::coord_t                     m_box_min_z,
    output tfn_pkg::coord_t                     m_box_max_x,
    output tfn_pkg::coord_t                     m_box_max_y,
    output tfn_pkg::coord_t                     m_box_max_z
);

    tfn_pkg::cmd_t cmd;
    tfn_pkg::sts_t sts;

    tfn_ctrl #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tfn_datapath #(
        .MAX_VERTICES     (MAX_VERTICES),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_vertex_slot (s_vertex_slot),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_coord_z     (s_coord_z),
        .s_corner_a    (s_corner_a),
        .s_corner_b    (s_corner_b),
        .s_corner_c    (s_corner_c),
        .m_normal_x    (m_normal_x),
        .m_normal_y    (m_normal_y),
        .m_normal_z    (m_normal_z),
        .m_degenerate  (m_degenerate),
        .m_box_min_x   (m_box_min_x),
        .m_box_min_y   (m_box_min_y),
        .m_box_min_z   (m_box_min_z),
        .m_box_max_x   (m_box_max_x),
        .m_box_max_y   (m_box_max_y),
        .m_box_max_z   (m_box_max_z)
    );

endmodule
